// ===== design/rtlp_pkg.sv =====
// Shared types, codes and helpers for the padded TLV record parser.
// No dependencies; rtlp_parse, rtlp_resq, the top level and the testbench import this package.
package rtlp_pkg;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_PREFIX,
		PH_TAG,
		PH_TYPE,
		PH_LEN,
		PH_VALUE,
		PH_PAD,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER,
		KIND_RECORD,
		KIND_VALUE,
		KIND_STATUS
	} kind_t;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
	localparam logic [2:0] ST_SIZE_SMALL = 3'd2;
	localparam logic [2:0] ST_INCOMPLETE = 3'd3;
	localparam logic [2:0] ST_TRUNCATED  = 3'd4;
	localparam logic [2:0] ST_BAD_TYPE   = 3'd5;

	localparam logic [15:0] HdrBytes = 16'd4;
	localparam logic [15:0] CountMax = 16'hFFFF;

	localparam int ResqDepth = 4;
	localparam int ResqAw    = $clog2(ResqDepth);

	typedef struct packed {
		kind_t       kind;
		logic [31:0] tag;
		logic [4:0]  rtype;
		logic [15:0] vlen;
		logic [7:0]  vbyte;
		logic [15:0] msize;
		logic [15:0] ssize;
		logic        prefix;
		logic [2:0]  status;
		logic        last;
	} result_t;

	// Results produced by one byte: n is 0, 1 or 2; r1 is used only when n is 2.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic type_ok(input logic [15:0] t);
		return t == 16'd1 || t == 16'd2 || t == 16'd5 || t == 16'd6 ||
			t == 16'd7 || t == 16'd20;
	endfunction

endpackage

// ===== design/rtlp_in_if.sv =====
// Byte input channel of the parser: valid/ready handshake plus the byte payload.
// No dependencies.
interface rtlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source(output valid, data_byte, end_of_buffer, input ready);
	modport sink(input valid, data_byte, end_of_buffer, output ready);
endinterface

// ===== design/rtlp_out_if.sv =====
// Result output channel of the parser: valid/ready handshake plus result fields.
// No dependencies.
interface rtlp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [31:0] record_tag;
	logic [4:0]  record_type;
	logic [15:0] value_length;
	logic [7:0]  value_byte;
	logic [15:0] message_size;
	logic [15:0] second_size;
	logic        prefix_present;
	logic [2:0]  status;
	logic        run_last;

	modport source(output valid, result_kind, record_tag, record_type, value_length,
		value_byte, message_size, second_size, prefix_present, status, run_last,
		input ready);
	modport sink(input valid, result_kind, record_tag, record_type, value_length,
		value_byte, message_size, second_size, prefix_present, status, run_last,
		output ready);
endinterface

// ===== design/rtlp_parse.sv =====
// Input register and per-byte parse logic: updates the message state and forms
// up to two results per byte. Depends on rtlp_pkg and rtlp_in_if.
module rtlp_parse import rtlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rtlp_in_if.sink   msg,
	input  logic      room,
	output push_t     push
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eob_s1;
	logic        fire;

	phase_t      phase_q, ph_d;
	logic [15:0] bc_q, bc_d;
	logic [15:0] size_q, size_d;
	logic [15:0] second_q, second_d;
	logic [31:0] shift_q, shift_d;
	logic [15:0] type_q, type_d;
	logic [15:0] vleft_q, vleft_d;
	logic [1:0]  pad_q, pad_d;
	logic        prefix_q, prefix_d;
	logic [2:0]  err_q, err_d;
	logic [1:0]  pc_q, pc_d;

	assign fire      = valid_s1 && room;
	assign msg.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			byte_s1 <= msg.data_byte;
			eob_s1  <= msg.end_of_buffer;
		end
	end

	always_comb begin
		logic [15:0] pos;
		logic [2:0]  pc_inc;
		logic        clean;
		logic        hdr_done;
		logic [2:0]  st;
		logic        prim_v;
		result_t     prim;
		result_t     stat;

		ph_d     = phase_q;
		bc_d     = bc_q;
		size_d   = size_q;
		second_d = second_q;
		shift_d  = shift_q;
		type_d   = type_q;
		vleft_d  = vleft_q;
		pad_d    = pad_q;
		prefix_d = prefix_q;
		err_d    = err_q;
		pc_d     = pc_q;
		prim     = '0;
		prim_v   = 1'b0;
		stat     = '0;
		clean    = 1'b0;
		st       = ST_OK;
		pos      = bc_q;
		pc_inc   = {1'b0, pc_q} + 3'd1;

		if (pos < HdrBytes) begin
			if (pos < 16'd2) begin
				size_d = {size_q[7:0], byte_s1};
			end else begin
				second_d = {second_q[7:0], byte_s1};
			end
			if (pos == 16'd3) begin
				prim_v     = 1'b1;
				prim.kind  = KIND_HEADER;
				prim.msize = size_d;
				prim.ssize = second_d;
				pc_d       = 2'd0;
				shift_d    = '0;
				ph_d       = (size_d <= HdrBytes) ? PH_DONE : PH_PREFIX;
			end
		end else if (phase_q != PH_DONE && pos < size_q) begin
			unique case (phase_q)
				PH_PREFIX, PH_TAG: begin
					shift_d = {shift_q[23:0], byte_s1};
					pc_d    = pc_inc[1:0];
					if (pc_inc == 3'd4) begin
						pc_d = 2'd0;
						// An all-zero first word of the body is the optional prefix.
						if (phase_q == PH_PREFIX && shift_d == '0) begin
							prefix_d = 1'b1;
							ph_d     = PH_TAG;
						end else begin
							type_d = '0;
							ph_d   = PH_TYPE;
						end
					end
				end
				PH_TYPE: begin
					type_d = {type_q[7:0], byte_s1};
					pc_d   = pc_inc[1:0];
					if (pc_inc == 3'd2) begin
						pc_d = 2'd0;
						if (type_ok(type_d)) begin
							vleft_d = '0;
							ph_d    = PH_LEN;
						end else begin
							if (err_q == ST_OK) begin
								err_d = ST_BAD_TYPE;
							end
							ph_d = PH_DONE;
						end
					end
				end
				PH_LEN: begin
					vleft_d = {vleft_q[7:0], byte_s1};
					pc_d    = pc_inc[1:0];
					if (pc_inc == 3'd2) begin
						pc_d       = 2'd0;
						prim_v     = 1'b1;
						prim.kind  = KIND_RECORD;
						prim.tag   = shift_q;
						prim.rtype = type_q[4:0];
						prim.vlen  = vleft_d;
						pad_d      = 2'd0 - vleft_d[1:0];
						if (vleft_d != '0) begin
							ph_d = PH_VALUE;
						end else begin
							ph_d = (pad_d != 2'd0) ? PH_PAD : PH_TAG;
						end
					end
				end
				PH_VALUE: begin
					prim_v     = 1'b1;
					prim.kind  = KIND_VALUE;
					prim.vbyte = byte_s1;
					vleft_d    = vleft_q - 16'd1;
					if (vleft_d == '0) begin
						ph_d = (pad_q != 2'd0) ? PH_PAD : PH_TAG;
					end
				end
				PH_PAD: begin
					pad_d = pad_q - 2'd1;
					if (pad_d == 2'd0) begin
						ph_d = PH_TAG;
					end
				end
				default: begin
					ph_d = PH_DONE;
				end
			endcase
		end

		if (bc_q != CountMax) begin
			bc_d = bc_q + 16'd1;
		end

		// The body ends here: only a record boundary or a cut pad counts as clean.
		if (ph_d != PH_HDR && ph_d != PH_DONE && bc_d >= HdrBytes && bc_d == size_d) begin
			clean = (ph_d == PH_PAD) || (ph_d == PH_TAG && pc_d == 2'd0);
			if (!clean && err_d == ST_OK) begin
				err_d = ST_TRUNCATED;
			end
			ph_d = PH_DONE;
		end

		hdr_done = bc_d >= HdrBytes;
		priority if (!hdr_done) begin
			st = ST_SHORT_HDR;
		end else if (size_d < HdrBytes) begin
			st = ST_SIZE_SMALL;
		end else if (bc_d < size_d) begin
			st = ST_INCOMPLETE;
		end else begin
			st = err_d;
		end
		stat.kind   = KIND_STATUS;
		stat.msize  = hdr_done ? size_d : '0;
		stat.ssize  = hdr_done ? second_d : '0;
		stat.prefix = prefix_d;
		stat.status = st;
		stat.last   = 1'b1;

		prim.last = !eob_s1;
		push.n    = fire ? ({1'b0, prim_v} + {1'b0, eob_s1}) : 2'd0;
		push.r0   = prim_v ? prim : stat;
		push.r1   = stat;

		// The end status closes the message; the next byte starts a new one.
		if (eob_s1) begin
			ph_d     = PH_HDR;
			bc_d     = '0;
			size_d   = '0;
			second_d = '0;
			shift_d  = '0;
			type_d   = '0;
			vleft_d  = '0;
			pad_d    = '0;
			prefix_d = 1'b0;
			err_d    = ST_OK;
			pc_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			bc_q     <= '0;
			size_q   <= '0;
			second_q <= '0;
			shift_q  <= '0;
			type_q   <= '0;
			vleft_q  <= '0;
			pad_q    <= '0;
			prefix_q <= 1'b0;
			err_q    <= ST_OK;
			pc_q     <= '0;
		end else if (fire) begin
			phase_q  <= ph_d;
			bc_q     <= bc_d;
			size_q   <= size_d;
			second_q <= second_d;
			shift_q  <= shift_d;
			type_q   <= type_d;
			vleft_q  <= vleft_d;
			pad_q    <= pad_d;
			prefix_q <= prefix_d;
			err_q    <= err_d;
			pc_q     <= pc_d;
		end
	end

`ifndef SYNTHESIS
	a_eob_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eob_s1 |=> phase_q == PH_HDR && bc_q == '0)
		else $error("state not cleared after end of buffer");

	a_hdr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q < HdrBytes |-> phase_q == PH_HDR)
		else $error("left header phase before four bytes");

	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r1.kind == KIND_STATUS && push.r0.kind != KIND_STATUS)
		else $error("second result of a byte is not the end status");
`endif

endmodule

// ===== design/rtlp_resq.sv =====
// Result queue: takes one or two results per cycle while it has room, hands out one per item.
// Depends on rtlp_pkg and rtlp_out_if.
module rtlp_resq import rtlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       room,
	rtlp_out_if.source res
);

	result_t           mem_q [ResqDepth];
	logic [ResqAw-1:0] wr_ptr_q;
	logic [ResqAw-1:0] rd_ptr_q;
	logic [ResqAw:0]   cnt_q;
	logic              pop;
	result_t           head;

	assign room      = cnt_q <= (ResqAw + 1)'(ResqDepth - 2);
	assign pop       = res.valid && res.ready;
	assign res.valid = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];

	assign res.result_kind    = head.kind;
	assign res.record_tag     = head.tag;
	assign res.record_type    = head.rtype;
	assign res.value_length   = head.vlen;
	assign res.value_byte     = head.vbyte;
	assign res.message_size   = head.msize;
	assign res.second_size    = head.ssize;
	assign res.prefix_present = head.prefix;
	assign res.status         = head.status;
	assign res.run_last       = head.last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + ResqAw'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ResqAw'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ResqAw'(1);
			end
			cnt_q <= cnt_q + (ResqAw + 1)'(push.n) - (ResqAw + 1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (ResqAw + 1)'(ResqDepth))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("results pushed without room");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(head))
		else $error("waiting result changed or dropped");
`endif

endmodule

// ===== design/padded_tlv_record_parser_top.sv =====
// Top level of the padded TLV record parser: parse stage and result queue.
// Depends on rtlp_pkg, rtlp_in_if, rtlp_out_if, rtlp_parse and rtlp_resq.
//
//   channel | modport     | item
//   msg     | rtlp sink   | one message byte and its end-of-buffer mark
//   res     | rtlp source | one result: header, record start, value byte or status
//
// One byte is taken per cycle while not stalled; from the input register its results
// go to the queue. A byte makes at most two results and the queue drains one per cycle
// while the receiver is ready. The input stalls while the four-entry result queue has
// fewer than two free slots and a byte is held. Reset returns the parser to the header
// phase; no clearing pass is needed.
module padded_tlv_record_parser_top import rtlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rtlp_in_if.sink    msg,
	rtlp_out_if.source res
);

	logic  room;
	push_t push;

	rtlp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.room   (room),
		.push   (push)
	);

	rtlp_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.res    (res)
	);

endmodule

// ===== dv/padded_tlv_record_parser_top_tb.sv =====
// Self-checking testbench for padded_tlv_record_parser_top: directed and random messages.
// Predicts every result from the byte stream and checks each result field by field.
// Depends on rtlp_pkg, rtlp_in_if, rtlp_out_if and the parser RTL.
module padded_tlv_record_parser_top_tb;
	import rtlp_pkg::*;

	localparam logic [15:0] RecordTypes [6] = '{16'd1, 16'd2, 16'd5, 16'd6, 16'd7, 16'd20};

	logic clk;
	logic arst_n;

	rtlp_in_if  msg_if();
	rtlp_out_if res_if();

	padded_tlv_record_parser_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_if),
		.res(res_if)
	);

	result_t    expected_results[$];
	logic [7:0] body_q[$];
	int         error_count = 0;
	int         bytes_sent = 0;
	int         hold_off_cycles = 0;
	bit         sender_idles = 1'b1;
	bit         receiver_idles = 1'b1;

	// Parser state as predicted from the accepted bytes.
	phase_t      ps_phase;
	logic [15:0] ps_count;
	logic [15:0] ps_size;
	logic [15:0] ps_second;
	logic [31:0] ps_field;
	logic [15:0] ps_type;
	logic [15:0] ps_left;
	logic [1:0]  ps_pad;
	logic        ps_prefix;
	logic [2:0]  ps_error;
	int          ps_part;

	always #6 clk = ~clk;

	function automatic bit is_record_type(input logic [15:0] t);
		foreach (RecordTypes[k]) begin
			if (RecordTypes[k] == t)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic clear_parser();
		ps_phase = PH_HDR;
		ps_count = '0;
		ps_size = '0;
		ps_second = '0;
		ps_field = '0;
		ps_type = '0;
		ps_left = '0;
		ps_pad = '0;
		ps_prefix = 1'b0;
		ps_error = ST_OK;
		ps_part = 0;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic eob);
		result_t     made[2];
		int          n;
		logic [15:0] pos;
		logic        clean;
		logic        hdr_done;
		n = 0;
		pos = ps_count;
		made[0] = '0;
		made[1] = '0;
		if (pos < HdrBytes) begin
			if (pos < 16'd2)
				ps_size = {ps_size[7:0], b};
			else
				ps_second = {ps_second[7:0], b};
			if (pos == 16'd3) begin
				made[n].kind = KIND_HEADER;
				made[n].msize = ps_size;
				made[n].ssize = ps_second;
				n++;
				ps_part = 0;
				ps_field = '0;
				ps_phase = (ps_size <= HdrBytes) ? PH_DONE : PH_PREFIX;
			end
		end else if (ps_phase != PH_DONE && pos < ps_size) begin
			case (ps_phase)
				PH_PREFIX, PH_TAG: begin
					ps_field = {ps_field[23:0], b};
					ps_part++;
					if (ps_part == 4) begin
						ps_part = 0;
						if (ps_phase == PH_PREFIX && ps_field == '0) begin
							ps_prefix = 1'b1;
							ps_phase = PH_TAG;
						end else begin
							ps_type = '0;
							ps_phase = PH_TYPE;
						end
					end
				end
				PH_TYPE: begin
					ps_type = {ps_type[7:0], b};
					ps_part++;
					if (ps_part == 2) begin
						ps_part = 0;
						if (is_record_type(ps_type)) begin
							ps_left = '0;
							ps_phase = PH_LEN;
						end else begin
							if (ps_error == ST_OK)
								ps_error = ST_BAD_TYPE;
							ps_phase = PH_DONE;
						end
					end
				end
				PH_LEN: begin
					ps_left = {ps_left[7:0], b};
					ps_part++;
					if (ps_part == 2) begin
						ps_part = 0;
						made[n].kind = KIND_RECORD;
						made[n].tag = ps_field;
						made[n].rtype = ps_type[4:0];
						made[n].vlen = ps_left;
						n++;
						// Pad up to the next multiple of four.
						ps_pad = 2'd0 - ps_left[1:0];
						if (ps_left != '0)
							ps_phase = PH_VALUE;
						else
							ps_phase = (ps_pad != '0) ? PH_PAD : PH_TAG;
					end
				end
				PH_VALUE: begin
					made[n].kind = KIND_VALUE;
					made[n].vbyte = b;
					n++;
					ps_left--;
					if (ps_left == '0)
						ps_phase = (ps_pad != '0) ? PH_PAD : PH_TAG;
				end
				PH_PAD: begin
					ps_pad--;
					if (ps_pad == '0)
						ps_phase = PH_TAG;
				end
				default: ps_phase = PH_DONE;
			endcase
		end

		if (ps_count != CountMax)
			ps_count++;

		// The body ends here: only a record boundary or a pad counts as clean.
		if (ps_phase != PH_HDR && ps_phase != PH_DONE && ps_count >= HdrBytes &&
				ps_count == ps_size) begin
			clean = ps_phase == PH_PAD || (ps_phase == PH_TAG && ps_part == 0);
			if (!clean && ps_error == ST_OK)
				ps_error = ST_TRUNCATED;
			ps_phase = PH_DONE;
		end

		if (eob) begin
			hdr_done = ps_count >= HdrBytes;
			made[n].kind = KIND_STATUS;
			if (!hdr_done)
				made[n].status = ST_SHORT_HDR;
			else if (ps_size < HdrBytes)
				made[n].status = ST_SIZE_SMALL;
			else if (ps_count < ps_size)
				made[n].status = ST_INCOMPLETE;
			else
				made[n].status = ps_error;
			made[n].msize = hdr_done ? ps_size : 16'd0;
			made[n].ssize = hdr_done ? ps_second : 16'd0;
			made[n].prefix = ps_prefix;
			n++;
			clear_parser();
		end

		if (n > 0)
			made[n - 1].last = 1'b1;
		for (int k = 0; k < n; k++)
			expected_results.insert(expected_results.size(), made[k]);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eob);
		while (sender_idles && $urandom_range(99) < 12) begin
			msg_if.valid <= 1'b0;
			@(posedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.data_byte <= b;
		msg_if.end_of_buffer <= eob;
		@(posedge clk);
		while (!msg_if.ready)
			@(posedge clk);
		bytes_sent++;
		predict_byte(b, eob);
	endtask

	task automatic put_byte(input logic [7:0] v);
		body_q.insert(body_q.size(), v);
	endtask

	task automatic add16(input logic [15:0] v);
		put_byte(v[15:8]);
		put_byte(v[7:0]);
	endtask

	task automatic add32(input logic [31:0] v);
		add16(v[31:16]);
		add16(v[15:0]);
	endtask

	task automatic add_record(input logic [31:0] tag, input logic [15:0] rtype, input int len,
			input bit short_pad);
		int pad;
		add32(tag);
		add16(rtype);
		add16(16'(len));
		repeat (len) put_byte(8'($urandom));
		pad = (4 - len % 4) % 4;
		if (short_pad && pad > 0)
			pad = $urandom_range(pad - 1);
		repeat (pad) put_byte(8'($urandom));
	endtask

	// Sends header plus queued body as a buffer of buf_len bytes; bytes beyond the
	// body are random filler, and the last byte carries the end-of-buffer mark.
	task automatic send_message(input logic [15:0] size_field, input logic [15:0] second,
			input int buf_len);
		logic [7:0] head[4];
		logic [7:0] b;
		head = '{size_field[15:8], size_field[7:0], second[15:8], second[7:0]};
		for (int i = 0; i < buf_len; i++) begin
			if (i < 4)
				b = head[i];
			else if (i - 4 < body_q.size())
				b = body_q[i - 4];
			else
				b = 8'($urandom);
			send_byte(b, i == buf_len - 1);
		end
		body_q.delete();
	endtask

	task automatic test_header_cases();
		send_message(16'h0000, 16'hFFFF, 2);
		send_message(16'hFFFF, 16'hFFFF, 4);
		send_message(16'h0003, 16'h0000, 4);
		send_message(16'h0004, 16'h8001, 4);
	endtask

	task automatic test_record_types();
		int lens[6];
		lens = '{1, 0, 2, 4, 5, 3};
		add32(32'h0);
		for (int k = 0; k < 6; k++)
			add_record((k == 0) ? 32'hFFFF_FFFF : $urandom, RecordTypes[k], lens[k], k == 5);
		send_message(16'(4 + body_q.size()), 16'h00FF, 4 + body_q.size());
	endtask

	task automatic test_error_cases();
		// A bad type stops parsing; the following record is never reported.
		add_record(32'h1234_5678, 16'hFFFF, 2, 1'b0);
		add_record(32'h0000_0001, RecordTypes[3], 1, 1'b0);
		send_message(16'(4 + body_q.size()), 16'h0001, 4 + body_q.size());

		// Maximum value length cut short by the message size.
		add32(32'h8000_0000);
		add16(RecordTypes[4]);
		add16(16'hFFFF);
		repeat (3) put_byte(8'($urandom));
		send_message(16'(4 + body_q.size()), 16'h7FFF, 4 + body_q.size());

		// Body shorter than a tag, followed by bytes past the size.
		add16(16'h0000);
		send_message(16'd6, 16'h0000, 10);
	endtask

	task automatic random_message();
		int          nrec;
		int          len;
		int          pick;
		int          buf_len;
		logic [15:0] size_field;
		logic [15:0] rtype;
		pick = $urandom_range(99);
		if (pick < 5) begin
			send_message(16'($urandom), 16'($urandom), $urandom_range(1, 16));
			return;
		end
		if ($urandom_range(99) < 30)
			add32(32'h0);
		nrec = $urandom_range(0, 4);
		for (int k = 0; k < nrec; k++) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
			rtype = ($urandom_range(99) < 6) ? 16'($urandom) : RecordTypes[$urandom_range(5)];
			add_record($urandom, rtype, len, k == nrec - 1 && $urandom_range(3) == 0);
		end
		size_field = 16'(4 + body_q.size());
		buf_len = 4 + body_q.size();
		if (pick < 12)
			size_field = 16'($urandom_range(4));
		else if (pick < 22 && body_q.size() > 0)
			size_field = 16'(4 + $urandom_range(body_q.size() - 1));
		else if (pick < 30)
			buf_len = buf_len + $urandom_range(1, 6);
		else if (pick < 38)
			buf_len = $urandom_range(1, buf_len - 1);
		send_message(size_field, 16'($urandom), buf_len);
	endtask

	task automatic test_random_messages();
		int msgs;
		msgs = 0;
		while (bytes_sent < 1950) begin
			// A stretch of messages with both sides running flat out.
			sender_idles = !(msgs >= 40 && msgs < 70);
			receiver_idles = sender_idles;
			random_message();
			msgs++;
		end
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
	endtask

	task automatic test_result_backpressure();
		sender_idles = 1'b0;
		hold_off_cycles = 300;
		add_record(32'hA5A5_0001, RecordTypes[0], 60, 1'b0);
		send_message(16'(4 + body_q.size()), 16'h0102, 4 + body_q.size());
		sender_idles = 1'b1;
	endtask

	task automatic compare_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
			error_count++;
		end
	endtask

	// Result receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= !(receiver_idles && $urandom_range(99) < 12);
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d status %0d",
					$time, res_if.result_kind, res_if.status);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("result_kind", want.kind, res_if.result_kind);
				compare_field("record_tag", want.tag, res_if.record_tag);
				compare_field("record_type", want.rtype, res_if.record_type);
				compare_field("value_length", want.vlen, res_if.value_length);
				compare_field("value_byte", want.vbyte, res_if.value_byte);
				compare_field("message_size", want.msize, res_if.message_size);
				compare_field("second_size", want.ssize, res_if.second_size);
				compare_field("prefix_present", want.prefix, res_if.prefix_present);
				compare_field("status", want.status, res_if.status);
				compare_field("run_last", want.last, res_if.run_last);
			end
		end
	end

	initial begin
		#(12 * 400000);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		msg_if.valid = 1'b0;
		msg_if.data_byte = '0;
		msg_if.end_of_buffer = 1'b0;
		clear_parser();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_cases();
		test_record_types();
		test_error_cases();
		test_result_backpressure();
		test_random_messages();

		msg_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
design/rtlp_pkg.sv
design/rtlp_in_if.sv
design/rtlp_out_if.sv
design/rtlp_parse.sv
design/rtlp_resq.sv
design/padded_tlv_record_parser_top.sv
dv/padded_tlv_record_parser_top_tb.sv
